@@ hw/rtl/cspl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Counting sort placement package
// Shared widths, codes, state type and monitor struct for the placement engine.
// ----------------------------------------------------------------------------
package cspl_pkg;

	localparam int NUM_GROUPS_DEF = 256;
	localparam int MAX_CELLS_DEF  = 65536;

	localparam int ACT_W  = 3;
	localparam int GID_W  = 8;
	localparam int POS_W  = 17;
	localparam int STAT_W = 2;
	localparam int GIU_W  = 9;

	localparam logic [GIU_W-1:0] GIU_RESET = 9'd256;
	localparam logic [POS_W-1:0] VAL_MAX   = '1;

	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PREFIX = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PLACE  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_FIN
	} cspl_state_t;

	typedef struct packed {
		logic walking;
		logic sweeping;
	} cspl_mon_t;

endpackage
`default_nettype wire

@@ hw/rtl/cspl_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Counting sort placement channels
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
interface cspl_in_if;
	import cspl_pkg::*;

	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [GID_W-1:0] group_id;

	modport source (output valid, output action, output group_id, input ready);
	modport sink (input valid, input action, input group_id, output ready);
endinterface

interface cspl_out_if;
	import cspl_pkg::*;

	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  position;
	logic [STAT_W-1:0] status;

	modport source (output valid, output position, output status, input ready);
	modport sink (input valid, input position, input status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/cspl_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Group table
// Simple dual-port memory of group counters, one write and one registered read.
// ----------------------------------------------------------------------------
module cspl_table #(
	parameter int NUM_GROUPS = cspl_pkg::NUM_GROUPS_DEF,
	localparam int AW = $clog2(NUM_GROUPS)
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [cspl_pkg::POS_W-1:0] wdata,
	input  wire logic [AW-1:0]            raddr,
	output logic      [cspl_pkg::POS_W-1:0] rdata
);
	import cspl_pkg::*;

	logic [POS_W-1:0] mem [NUM_GROUPS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hw/rtl/cspl_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Placement sequencer
// Runs read-modify-write on the group table, the clearing sweep and the prefix
// walk, and holds the result register.
// ----------------------------------------------------------------------------
module cspl_ctrl #(
	parameter int NUM_GROUPS = cspl_pkg::NUM_GROUPS_DEF,
	parameter int MAX_CELLS  = cspl_pkg::MAX_CELLS_DEF,
	localparam int AW = $clog2(NUM_GROUPS),
	localparam int LW = ($clog2(NUM_GROUPS + 1) > cspl_pkg::GIU_W) ?
		$clog2(NUM_GROUPS + 1) : cspl_pkg::GIU_W
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [LW-1:0]              lim,
	cspl_in_if.sink                         item,
	cspl_out_if.source                      result,
	output logic                            tbl_we,
	output logic      [AW-1:0]              tbl_waddr,
	output logic      [cspl_pkg::POS_W-1:0] tbl_wdata,
	output logic      [AW-1:0]              tbl_raddr,
	input  wire logic [cspl_pkg::POS_W-1:0] tbl_rdata,
	output cspl_pkg::cspl_mon_t             mon
);
	import cspl_pkg::*;

	localparam int SW = POS_W + 1 + AW;
	localparam int CW = (SW > 26) ? SW : 26;
	localparam logic [POS_W-1:0] CAP =
		(MAX_CELLS < (2**POS_W - 1)) ? POS_W'(MAX_CELLS) : VAL_MAX;
	localparam logic [LW-1:0] LAST_IDX = LW'(NUM_GROUPS - 1);

	cspl_state_t       state_q, state_d;
	logic [ACT_W-1:0]  act_q;
	logic [GID_W-1:0]  g_q;
	logic [LW-1:0]     idx_q;
	logic [AW-1:0]     wr_idx_s1;
	logic              rd_vld_s1;
	logic [SW-1:0]     sum_q;
	logic [POS_W-1:0]  cell_total_q;
	logic              res_pend_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic [STAT_W-1:0] stat_q;

	logic              accept;
	logic              out_free;
	logic              g_oor;
	logic              issue;
	logic              walk_end;
	logic              over;
	logic              load;
	logic              inc_ct;
	logic [POS_W-1:0]  res_pos;
	logic [STAT_W-1:0] res_stat;

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	assign g_oor    = LW'(g_q) >= lim;
	assign issue    = (state_q == S_WALK) && (idx_q < lim);
	assign walk_end = (state_q == S_WALK) && !issue && !rd_vld_s1;
	assign over     = CW'(sum_q) > CW'(MAX_CELLS);

	assign item.ready      = (state_q == S_IDLE);
	assign result.valid    = out_valid_q;
	assign result.position = pos_q;
	assign result.status   = stat_q;

	assign mon.walking  = (state_q == S_WALK);
	assign mon.sweeping = (state_q == S_SWEEP);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_SWEEP: begin
				if (idx_q == LAST_IDX) begin
					state_d = res_pend_q ? S_FIN : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (item.action)
						ACT_CLEAR:  state_d = S_SWEEP;
						ACT_PREFIX: state_d = S_WALK;
						default:    state_d = S_EXEC;
					endcase
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				if (walk_end) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Table port control and result selection.
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = idx_q[AW-1:0];
		tbl_wdata = '0;
		tbl_raddr = AW'(g_q);
		inc_ct    = 1'b0;
		res_pos   = '0;
		res_stat  = STAT_OK;
		load      = 1'b0;
		case (state_q)
			S_SWEEP: begin
				tbl_we = 1'b1;
			end
			S_IDLE: begin
				tbl_raddr = AW'(item.group_id);
			end
			S_EXEC: begin
				load      = out_free;
				tbl_waddr = AW'(g_q);
				tbl_wdata = tbl_rdata + POS_W'(1);
				case (act_q)
					ACT_COUNT: begin
						if (g_oor) begin
							res_stat = STAT_RANGE;
						end else if (cell_total_q >= CAP || tbl_rdata >= VAL_MAX) begin
							res_stat = STAT_OVER;
						end else begin
							tbl_we = out_free;
							inc_ct = out_free;
						end
					end
					ACT_PLACE: begin
						if (g_oor) begin
							res_stat = STAT_RANGE;
						end else if (tbl_rdata >= CAP) begin
							res_stat = STAT_OVER;
						end else begin
							res_pos = tbl_rdata;
							tbl_we  = out_free;
						end
					end
					ACT_QUERY: begin
						if (g_oor) begin
							res_stat = STAT_RANGE;
						end else begin
							res_pos = tbl_rdata;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				// Read one group ahead while the previous one is written back.
				tbl_raddr = idx_q[AW-1:0];
				tbl_waddr = wr_idx_s1;
				tbl_wdata = sum_q[POS_W-1:0];
				tbl_we    = rd_vld_s1;
			end
			S_FIN: begin
				load = out_free;
				if (act_q == ACT_PREFIX) begin
					res_pos  = sum_q[POS_W-1:0];
					res_stat = over ? STAT_OVER : STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			cell_total_q <= '0;
			res_pend_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (accept) begin
				idx_q <= '0;
				if (item.action == ACT_CLEAR) begin
					res_pend_q   <= 1'b1;
					cell_total_q <= '0;
				end
			end else if (state_q == S_SWEEP || issue) begin
				idx_q <= idx_q + LW'(1);
			end
			if (inc_ct) begin
				cell_total_q <= cell_total_q + POS_W'(1);
			end
			if (state_q == S_FIN && out_free) begin
				res_pend_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= item.action;
			g_q   <= item.group_id;
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SW'(tbl_rdata);
		end
		wr_idx_s1 <= idx_q[AW-1:0];
		if (load) begin
			pos_q  <= res_pos;
			stat_q <= res_stat;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/counting_sort_placement.sv @@
`default_nettype none
// Count, place, query and unknown actions: the table read is registered, then
// the result register loads once the output is free, and only then is the input ready.
// Prefix: one table entry per cycle of the walk.
// Clear: the sweep writes one table entry per cycle.
// After reset the same sweep runs with the input not ready.
// ----------------------------------------------------------------------------
// Counting sort placement engine
// Stable counting-sort group table with clear, count, prefix, place and query actions.
// ----------------------------------------------------------------------------
module counting_sort_placement #(
	parameter int NUM_GROUPS = cspl_pkg::NUM_GROUPS_DEF,
	parameter int MAX_CELLS  = cspl_pkg::MAX_CELLS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [cspl_pkg::GIU_W-1:0] cfg_wdata,
	cspl_in_if.sink                         item,
	cspl_out_if.source                      result
);
	import cspl_pkg::*;

	localparam int AW = $clog2(NUM_GROUPS);
	localparam int LW = ($clog2(NUM_GROUPS + 1) > GIU_W) ? $clog2(NUM_GROUPS + 1) : GIU_W;
	localparam logic [LW-1:0] NG_L = LW'(NUM_GROUPS);

	logic [GIU_W-1:0] giu_q;
	logic [LW-1:0]    giu_ext;
	logic [LW-1:0]    lim;
	logic             tbl_we;
	logic [AW-1:0]    tbl_waddr;
	logic [POS_W-1:0] tbl_wdata;
	logic [AW-1:0]    tbl_raddr;
	logic [POS_W-1:0] tbl_rdata;
	cspl_mon_t        mon;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			giu_q <= GIU_RESET;
		end else if (cfg_we) begin
			giu_q <= cfg_wdata;
		end
	end

	// Group ids at or above the smaller of the register and the table depth are invalid.
	assign giu_ext = LW'(giu_q);
	assign lim     = (giu_ext > NG_L) ? NG_L : giu_ext;

	cspl_ctrl #(
		.NUM_GROUPS (NUM_GROUPS),
		.MAX_CELLS  (MAX_CELLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.lim       (lim),
		.item      (item),
		.result    (result),
		.tbl_we    (tbl_we),
		.tbl_waddr (tbl_waddr),
		.tbl_wdata (tbl_wdata),
		.tbl_raddr (tbl_raddr),
		.tbl_rdata (tbl_rdata),
		.mon       (mon)
	);

	cspl_table #(
		.NUM_GROUPS (NUM_GROUPS)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// The prefix walk must never write the entry it is reading in the same cycle.
	a_walk_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mon.walking && tbl_we |-> tbl_waddr != tbl_raddr)
		else $error("prefix walk wrote the entry being read");

	a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		mon.sweeping |-> !item.ready)
		else $error("input ready during the clearing sweep");

	a_sweep_writes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mon.sweeping |-> tbl_we && tbl_wdata == '0)
		else $error("clearing sweep did not write zero");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second word taken while one is in progress");

endmodule
`default_nettype wire
